/* sv/tfn_pkg.sv */
// Shared constants for the triangle face normal unit.
package tfn_pkg;

   // Depth of the queue between the front and the back part, and its pointer width.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   // Width of each normal component on the result ports.
   localparam int NORMAL_BITS = 16;

   // Control state of one pipeline stage.
   typedef struct packed {
      logic valid;
      logic last;
      logic degen;
   } stage_ctl_type;

endpackage

/* sv/tfn_front.sv */
// Front part: edge vectors, cross product, component magnitudes and their squares.
module tfn_front
   import tfn_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int MAG_BITS   = 34,
   parameter int DATA_BITS  = 315
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] az,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] bz,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic signed [COORD_BITS-1:0] cz,
   input  logic                         last_triangle,
   input  logic                         push,
   output logic                         full,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [DATA_BITS-1:0]         out_data
);

   localparam int EW   = COORD_BITS + 1;
   localparam int PRW  = 2 * EW;
   localparam int CW   = PRW + 1;
   localparam int HB   = COORD_BITS + 1;
   localparam int SQW  = 2 * MAG_BITS;

   logic signed [EW-1:0]  e1 [0:2];
   logic signed [EW-1:0]  e2 [0:2];
   logic signed [PRW-1:0] p_in [0:2];
   logic signed [PRW-1:0] q_in [0:2];
   logic signed [CW-1:0]  cd [0:2];
   logic [MAG_BITS-1:0]   m_in [0:2];
   logic [2:0]            neg_in;
   logic [MAG_BITS-1:0]   hh_in [0:2];
   logic [MAG_BITS-1:0]   hl_in [0:2];
   logic [MAG_BITS-1:0]   ll_in [0:2];
   logic [SQW-1:0]        sq_in [0:2];

   stage_ctl_type         c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [PRW-1:0] p1_ff [0:2];
   logic signed [PRW-1:0] q1_ff [0:2];
   logic [MAG_BITS-1:0]   m2_ff [0:2];
   logic [2:0]            neg2_ff;
   logic [MAG_BITS-1:0]   m3_ff [0:2];
   logic [2:0]            neg3_ff;
   logic [MAG_BITS-1:0]   hh3_ff [0:2];
   logic [MAG_BITS-1:0]   hl3_ff [0:2];
   logic [MAG_BITS-1:0]   ll3_ff [0:2];
   logic [MAG_BITS-1:0]   m4_ff [0:2];
   logic [2:0]            neg4_ff;
   logic [SQW-1:0]        sq4_ff [0:2];

   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4      = !c4_ff.valid || out_ready;
   assign rdy3      = !c3_ff.valid || rdy4;
   assign rdy2      = !c2_ff.valid || rdy3;
   assign rdy1      = !c1_ff.valid || rdy2;
   assign full      = !rdy1;
   assign out_valid = c4_ff.valid;

   always_comb begin
      e1[0] = EW'(bx) - EW'(ax);
      e1[1] = EW'(by) - EW'(ay);
      e1[2] = EW'(bz) - EW'(az);
      e2[0] = EW'(cx) - EW'(ax);
      e2[1] = EW'(cy) - EW'(ay);
      e2[2] = EW'(cz) - EW'(az);
      p_in[0] = e1[1] * e2[2];
      q_in[0] = e1[2] * e2[1];
      p_in[1] = e1[2] * e2[0];
      q_in[1] = e1[0] * e2[2];
      p_in[2] = e1[0] * e2[1];
      q_in[2] = e1[1] * e2[0];
      for (int l = 0; l < 3; l++) begin
         cd[l]     = CW'(p1_ff[l]) - CW'(q1_ff[l]);
         neg_in[l] = cd[l][CW-1];
         m_in[l]   = neg_in[l] ? MAG_BITS'(-cd[l]) : MAG_BITS'(cd[l]);
         hh_in[l]  = MAG_BITS'(m2_ff[l][MAG_BITS-1:HB] * m2_ff[l][MAG_BITS-1:HB]);
         hl_in[l]  = MAG_BITS'(m2_ff[l][MAG_BITS-1:HB] * m2_ff[l][HB-1:0]);
         ll_in[l]  = MAG_BITS'(m2_ff[l][HB-1:0] * m2_ff[l][HB-1:0]);
         sq_in[l]  = (SQW'(hh3_ff[l]) << (2 * HB)) + (SQW'(hl3_ff[l]) << (HB + 1))
                   + SQW'(ll3_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
      end else begin
         if (rdy1) c1_ff.valid <= push;
         if (rdy2) c2_ff.valid <= c1_ff.valid;
         if (rdy3) c3_ff.valid <= c2_ff.valid;
         if (rdy4) c4_ff.valid <= c3_ff.valid;
      end
      if (rdy1 && push) begin
         c1_ff.last  <= last_triangle;
         c1_ff.degen <= 1'b0;
         p1_ff       <= p_in;
         q1_ff       <= q_in;
      end
      if (rdy2 && c1_ff.valid) begin
         c2_ff.last  <= c1_ff.last;
         // A zero cross product is the only case with every component zero.
         c2_ff.degen <= (cd[0] == '0) && (cd[1] == '0) && (cd[2] == '0);
         m2_ff       <= m_in;
         neg2_ff     <= neg_in;
      end
      if (rdy3 && c2_ff.valid) begin
         c3_ff.last  <= c2_ff.last;
         c3_ff.degen <= c2_ff.degen;
         m3_ff       <= m2_ff;
         neg3_ff     <= neg2_ff;
         hh3_ff      <= hh_in;
         hl3_ff      <= hl_in;
         ll3_ff      <= ll_in;
      end
      if (rdy4 && c3_ff.valid) begin
         c4_ff.last  <= c3_ff.last;
         c4_ff.degen <= c3_ff.degen;
         m4_ff       <= m3_ff;
         neg4_ff     <= neg3_ff;
         sq4_ff      <= sq_in;
      end
   end

   assign out_data = {c4_ff.last, c4_ff.degen, neg4_ff,
                      m4_ff[2], m4_ff[1], m4_ff[0],
                      sq4_ff[2], sq4_ff[1], sq4_ff[0]};

endmodule

/* sv/tfn_queue.sv */
// Short first-in first-out queue between the front and the back part.
module tfn_queue
   import tfn_pkg::*;
#(
   parameter int DATA_BITS = 315
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 empty,
   output logic [DATA_BITS-1:0] pop_data
);

   logic [DATA_BITS-1:0] slot_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* sv/tfn_back.sv */
// Back part: bit-serial pipelined search for the rounded unit normal components.
module tfn_back
   import tfn_pkg::*;
#(
   parameter int MAG_BITS         = 34,
   parameter int NORMAL_FRAC_BITS = 14,
   parameter int DATA_BITS        = 315
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [DATA_BITS-1:0]          in_data,
   output logic                          empty,
   input  logic                          pop,
   output logic signed [NORMAL_BITS-1:0] normal_x,
   output logic signed [NORMAL_BITS-1:0] normal_y,
   output logic signed [NORMAL_BITS-1:0] normal_z,
   output logic                          degenerate,
   output logic                          last_out
);

   localparam int F   = NORMAL_FRAC_BITS;
   localparam int NS  = F + 1;
   localparam int SQW = 2 * MAG_BITS;
   localparam int AW  = SQW + 2 * F + 9;
   localparam int QX  = (F + 2 > NORMAL_BITS) ? F + 2 : NORMAL_BITS;

   logic [SQW-1:0]       sq_u [0:2];
   logic [2:0]           neg_u;
   logic signed [AW-1:0] s0_in;

   stage_ctl_type        ctl_ff  [0:NS];
   logic [2:0]           neg_ff  [0:NS];
   logic signed [AW-1:0] s_ff    [0:NS];
   logic signed [AW-1:0] a_ff    [0:NS][0:2];
   logic signed [AW-1:0] b_ff    [0:NS][0:2];
   logic signed [AW-1:0] r_ff    [0:NS][0:2];
   logic [F:0]           q_ff    [0:NS][0:2];

   logic signed [AW-1:0] cand    [1:NS][0:2];
   logic signed [AW-1:0] a_in    [1:NS][0:2];
   logic signed [AW-1:0] b_in    [1:NS][0:2];
   logic [F:0]           q_in    [1:NS][0:2];
   logic                 rdy     [0:NS];
   logic signed [QX-1:0] qs      [0:2];

   assign sq_u[0] = in_data[SQW-1:0];
   assign sq_u[1] = in_data[2*SQW-1:SQW];
   assign sq_u[2] = in_data[3*SQW-1:2*SQW];
   assign neg_u   = in_data[3*SQW+3*MAG_BITS+2:3*SQW+3*MAG_BITS];
   assign s0_in   = $signed(AW'(sq_u[0])) + $signed(AW'(sq_u[1]))
                  + $signed(AW'(sq_u[2]));

   always_comb begin
      rdy[NS] = !ctl_ff[NS].valid || pop;
      for (int j = NS - 1; j >= 0; j--) begin
         rdy[j] = !ctl_ff[j].valid || rdy[j+1];
      end
   end
   assign in_ready = rdy[0];

   // Step j settles bit k = NS - j of q. With t = 2q - 1 the stage keeps
   // a = t*t*S and b = t*S, so setting bit k needs only shifts and adds.
   always_comb begin
      for (int j = 1; j <= NS; j++) begin
         for (int l = 0; l < 3; l++) begin
            cand[j][l] = a_ff[j-1][l] + (b_ff[j-1][l] <<< (NS - j + 2))
                       + (s_ff[j-1] <<< (2 * (NS - j) + 2));
            if (cand[j][l] <= r_ff[j-1][l]) begin
               a_in[j][l] = cand[j][l];
               b_in[j][l] = b_ff[j-1][l] + (s_ff[j-1] <<< (NS - j + 1));
               q_in[j][l] = q_ff[j-1][l] | ((F + 1)'(1) << (NS - j));
            end else begin
               a_in[j][l] = a_ff[j-1][l];
               b_in[j][l] = b_ff[j-1][l];
               q_in[j][l] = q_ff[j-1][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NS; j++) ctl_ff[j].valid <= 1'b0;
      end else begin
         if (rdy[0]) ctl_ff[0].valid <= in_valid;
         for (int j = 1; j <= NS; j++) begin
            if (rdy[j]) ctl_ff[j].valid <= ctl_ff[j-1].valid;
         end
      end
      if (rdy[0] && in_valid) begin
         ctl_ff[0].last  <= in_data[DATA_BITS-1];
         ctl_ff[0].degen <= in_data[DATA_BITS-2];
         neg_ff[0]       <= neg_u;
         s_ff[0]         <= s0_in;
         for (int l = 0; l < 3; l++) begin
            a_ff[0][l] <= s0_in;
            b_ff[0][l] <= -s0_in;
            r_ff[0][l] <= $signed(AW'(sq_u[l])) <<< (2 * F + 2);
            q_ff[0][l] <= '0;
         end
      end
      for (int j = 1; j <= NS; j++) begin
         if (rdy[j] && ctl_ff[j-1].valid) begin
            ctl_ff[j].last  <= ctl_ff[j-1].last;
            ctl_ff[j].degen <= ctl_ff[j-1].degen;
            neg_ff[j]       <= neg_ff[j-1];
            s_ff[j]         <= s_ff[j-1];
            for (int l = 0; l < 3; l++) begin
               a_ff[j][l] <= a_in[j][l];
               b_ff[j][l] <= b_in[j][l];
               r_ff[j][l] <= r_ff[j-1][l];
               q_ff[j][l] <= q_in[j][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         qs[l] = $signed(QX'(q_ff[NS][l]));
         if (neg_ff[NS][l]) qs[l] = -qs[l];
      end
   end

   assign empty      = !ctl_ff[NS].valid;
   assign degenerate = ctl_ff[NS].degen;
   assign last_out   = ctl_ff[NS].last;
   assign normal_x   = ctl_ff[NS].degen ? '0 : qs[0][NORMAL_BITS-1:0];
   assign normal_y   = ctl_ff[NS].degen ? '0 : qs[1][NORMAL_BITS-1:0];
   assign normal_z   = ctl_ff[NS].degen ? '0 : qs[2][NORMAL_BITS-1:0];

endmodule

/* sv/triangle_face_normal_unit_core.sv */
// The unit has 4 front stages, the queue and NORMAL_FRAC_BITS+2 back stages.
// It takes one triangle per cycle while full is low; each later back stage settles one bit of each component.
// The front and back pipelines advance per stage, so a stalled result only halts stages behind it.
// The 4-beat queue between the parts lets either stall without holding up the other until it fills or drains.
// Reset (synchronous, active high) empties every stage and the queue; no clearing pass is needed.
module triangle_face_normal_unit_core
   import tfn_pkg::*;
#(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_BITS-1:0]  req_ax,
   input  logic signed [COORD_BITS-1:0]  req_ay,
   input  logic signed [COORD_BITS-1:0]  req_az,
   input  logic signed [COORD_BITS-1:0]  req_bx,
   input  logic signed [COORD_BITS-1:0]  req_by,
   input  logic signed [COORD_BITS-1:0]  req_bz,
   input  logic signed [COORD_BITS-1:0]  req_cx,
   input  logic signed [COORD_BITS-1:0]  req_cy,
   input  logic signed [COORD_BITS-1:0]  req_cz,
   input  logic                          req_last_triangle,
   input  logic                          push,
   output logic                          full,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_z,
   output logic                          rsp_degenerate,
   output logic                          rsp_last_out,
   output logic                          empty,
   input  logic                          pop
);

   // Each cross product component has a magnitude of at most 2^(2*COORD_BITS+1).
   localparam int MAG_BITS  = 2 * COORD_BITS + 2;
   // One beat between the parts: squares, magnitudes, signs, degenerate flag and last mark.
   localparam int DATA_BITS = 3 * (2 * MAG_BITS) + 3 * MAG_BITS + 3 + 2;

   logic                 q_push, q_full, q_pop, q_empty;
   logic [DATA_BITS-1:0] q_wdata, q_rdata;

   // The front part forms the edges and the exact cross product, flags a zero
   // normal and squares each component with split multipliers.
   tfn_front #(
      .COORD_BITS (COORD_BITS),
      .MAG_BITS   (MAG_BITS),
      .DATA_BITS  (DATA_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .ax            (req_ax),
      .ay            (req_ay),
      .az            (req_az),
      .bx            (req_bx),
      .by            (req_by),
      .bz            (req_bz),
      .cx            (req_cx),
      .cy            (req_cy),
      .cz            (req_cz),
      .last_triangle (req_last_triangle),
      .push          (push),
      .full          (full),
      .out_valid     (q_push),
      .out_ready     (!q_full),
      .out_data      (q_wdata)
   );

   // The queue's full flag comes straight from its count register, which
   // keeps the ready path of the back part apart from that of the front.
   tfn_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_wdata),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   // The back part finds, one bit per stage, the largest q for which
   // (2q-1)^2 * |n|^2 <= 2^(2F+2) * n_i^2, which is the component rounded to
   // nearest with ties away from zero; the final stage is the result register.
   tfn_back #(
      .MAG_BITS         (MAG_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .DATA_BITS        (DATA_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!q_empty),
      .in_ready   (q_pop),
      .in_data    (q_rdata),
      .empty      (empty),
      .pop        (pop),
      .normal_x   (rsp_normal_x),
      .normal_y   (rsp_normal_y),
      .normal_z   (rsp_normal_z),
      .degenerate (rsp_degenerate),
      .last_out   (rsp_last_out)
   );

`ifndef SYNTHESIS
   // A degenerate result must carry an all-zero normal.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_degenerate) |->
      (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate result with a non-zero normal");

   // A unit normal always has a component of at least one over root three.
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_degenerate) |->
      (rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0))
      else $error("non-degenerate result with a zero normal");

   // A beat that the front part offers to a full queue must not be dropped; the front keeps offering it.
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      (q_full && q_push) |=> q_push)
      else $error("beat lost at the queue between front and back");
`endif

endmodule
